[rtl/core/itbd_pkg.sv]
package itbd_pkg;

  // conversion limits
  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int MAG_BITS   = VALUE_BITS - 1;

  // divider slices the dividend into fixed chunks, one chunk per cycle
  localparam int STEP_BITS  = 8;
  localparam int CHUNKS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_BITS  = CHUNKS * STEP_BITS;
  localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  // digit store addressing
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  // radix limits and field widths
  localparam int RADIX_W    = 5;
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  // ascii codes
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_NUL     = 8'h00;

  // classified item handed from front to back
  typedef struct packed {
    logic                negative;
    logic [MAG_BITS-1:0] magnitude;
    logic [RADIX_W-1:0]  radix;
    logic                upper;
  } cmd_t;

  // digit value to ascii glyph
  function automatic logic [7:0] glyph(input logic [3:0] digit, input logic upper);
    logic [7:0] code;
    if (digit < 4'd10) begin
      code = ASCII_ZERO + {4'h0, digit};
    end else begin
      code = (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + {4'h0, digit} - 8'd10;
    end
    return code;
  endfunction

endpackage

[rtl/core/integer_to_base_digits.sv]
// Integer to ASCII digits in a radix from 2 to 16.
// Input queue side: drive value, radix and upper_case with push; the item is
// taken on a clock edge where push is high and full is low. Two items can wait
// in the front queue while the back end converts an earlier one.
// Result queue side: while empty is low, character, last_digit and
// empty_string show the oldest result; pop high on a clock edge takes it.
// Digits come most significant first; last_digit marks the final one. A
// negative value gives one result with empty_string and last_digit set.
// Radix below 2 acts as 2, above 16 acts as 16.
// Flow: an item is registered in the front queue, then the back end, once
// idle, takes it and divides by the radix 8 bits per cycle, storing one digit
// per full pass over the dividend, and sends each digit by a store read, then
// the result register. The back end takes a new item only after it has sent
// the last result of the previous one. A negative value skips the division
// and goes straight to the result register. When pop is held low the back end
// waits on the result register, and the front queue keeps taking items until
// full rises.
// Reset (rst, synchronous) empties both queues and returns the back end to
// idle; the digit store is not cleared.
module integer_to_base_digits
  import itbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  input  logic                  upper_case,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            character,
  output logic                  last_digit,
  output logic                  empty_string
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // accept and classify items
  itbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .radix      (radix),
    .upper_case (upper_case),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // divide and emit digits
  itbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .empty        (empty),
    .pop          (pop),
    .character    (character),
    .last_digit   (last_digit),
    .empty_string (empty_string)
  );

endmodule

[rtl/core/itbd_front.sv]
module itbd_front
  import itbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  input  logic                  upper_case,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_take
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       classified;
  logic       do_push;
  logic       do_pop;

  // classify the incoming item: sign, magnitude, clamped radix
  always_comb begin
    classified.negative  = value[VALUE_BITS-1];
    classified.magnitude = value[MAG_BITS-1:0];
    classified.upper     = upper_case;
    if (radix < RADIX_MIN) begin
      classified.radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      classified.radix = RADIX_MAX;
    end else begin
      classified.radix = radix;
    end
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // two-entry queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= classified;
    end
  end

endmodule

[rtl/core/itbd_back.sv]
module itbd_back
  import itbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] character,
  output logic       last_digit,
  output logic       empty_string
);

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    EMIT_READ,
    EMIT_SEND,
    SEND_EMPTY
  } state_t;

  state_t               state;
  logic [WORK_BITS-1:0] work;
  logic [3:0]           rem;
  logic [CHUNK_W-1:0]   chunk;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     idx;
  logic [RADIX_W-1:0]   radix_r;
  logic                 upper_r;
  logic                 out_valid;

  logic [3:0]           store [MAX_DIGITS];
  logic [3:0]           rd_digit;
  logic                 store_we;

  logic [RADIX_W-1:0]   part_rem;
  logic [STEP_BITS-1:0] qbits;
  logic [WORK_BITS-1:0] work_next;
  logic                 digit_done;
  logic                 out_free;
  logic                 out_load;

  // one chunk of restoring division by the radix
  always_comb begin
    logic [RADIX_W-1:0] r;
    r     = {1'b0, rem};
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[3:0], work[WORK_BITS-1-i]};
      if (r >= radix_r) begin
        r = r - radix_r;
        qbits[STEP_BITS-1-i] = 1'b1;
      end
    end
    part_rem  = r;
    work_next = {work[WORK_BITS-STEP_BITS-1:0], qbits};
  end

  assign digit_done = (state == DIVIDE) && (chunk == CHUNK_W'(CHUNKS - 1));
  assign store_we   = digit_done;
  assign out_free   = !out_valid || pop;
  assign out_load   = out_free && (state == EMIT_SEND || state == SEND_EMPTY);
  assign empty      = !out_valid;
  assign cmd_take   = (state == IDLE);

  // digit store, registered read
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[count[IDX_W-1:0]] <= part_rem[3:0];
    end
    rd_digit <= store[idx];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      chunk     <= '0;
      count     <= '0;
      rem       <= '0;
      idx       <= '0;
    end else begin
      // result register fills on a send, drains on a pop
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (cmd_valid) begin
            radix_r <= cmd.radix;
            upper_r <= cmd.upper;
            work    <= WORK_BITS'(cmd.magnitude);
            rem     <= '0;
            chunk   <= '0;
            count   <= '0;
            state   <= cmd.negative ? SEND_EMPTY : DIVIDE;
          end
        end
        DIVIDE: begin
          work <= work_next;
          if (digit_done) begin
            chunk <= '0;
            rem   <= '0;
            count <= count + CNT_W'(1);
            if (work_next == '0 || count == CNT_W'(MAX_DIGITS - 1)) begin
              idx   <= count[IDX_W-1:0];
              state <= EMIT_READ;
            end
          end else begin
            chunk <= chunk + CHUNK_W'(1);
            rem   <= part_rem[3:0];
          end
        end
        EMIT_READ: begin
          state <= EMIT_SEND;
        end
        EMIT_SEND: begin
          if (out_free) begin
            character    <= glyph(rd_digit, upper_r);
            last_digit   <= (idx == '0);
            empty_string <= 1'b0;
            if (idx == '0) begin
              state <= IDLE;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= EMIT_READ;
            end
          end
        end
        SEND_EMPTY: begin
          if (out_free) begin
            character    <= ASCII_NUL;
            last_digit   <= 1'b1;
            empty_string <= 1'b1;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
